// ===== src/gsvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvc_pkg
// Shared types and constants for the go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package gsvc_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);

    localparam logic signed [19:0] AngPi     = 20'sd205887;
    localparam logic signed [19:0] AngHalfPi = 20'sd102944;
    localparam logic signed [20:0] AngTwoPi  = 21'sd411775;
    localparam logic signed [17:0] Q13Pi     = 18'sd25736;
    localparam logic signed [17:0] Q13TwoPi  = 18'sd51472;
    localparam logic signed [15:0] CordicK   = 16'sd9949;

    localparam logic [1:0] ModeDrive = 2'd0;
    localparam logic [1:0] ModeAlign = 2'd1;
    localparam logic [1:0] ModeClose = 2'd2;
    localparam logic [1:0] ModeTurn  = 2'd3;

    typedef struct packed {
        logic               command;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [31:0] robot_z;
        logic signed [15:0] robot_heading;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic               done_res;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_SCINIT, S_SC, S_ATINIT, S_AT, S_ANG,
        S_LIN1, S_LIN2, S_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic       mode;   // 0 rotation (sin/cos), 1 vectoring (atan2)
        logic signed [37:0] x0;
        logic signed [37:0] y0;
        logic signed [21:0] z0;
    } t_cordic_cmd;

    function automatic logic signed [21:0] atan_entry(input logic [4:0] i);
        logic signed [21:0] r;
        begin
            case (i)
                5'd0:  r = 22'sd51472;
                5'd1:  r = 22'sd30385;
                5'd2:  r = 22'sd16055;
                5'd3:  r = 22'sd8150;
                5'd4:  r = 22'sd4091;
                5'd5:  r = 22'sd2047;
                5'd6:  r = 22'sd1024;
                5'd7:  r = 22'sd512;
                5'd8:  r = 22'sd256;
                5'd9:  r = 22'sd128;
                5'd10: r = 22'sd64;
                5'd11: r = 22'sd32;
                5'd12: r = 22'sd16;
                5'd13: r = 22'sd8;
                5'd14: r = 22'sd4;
                5'd15: r = 22'sd2;
                5'd16: r = 22'sd1;
                5'd17: r = 22'sd1;
                default: r = 22'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        begin
            if (v > 48'sd32767) r = 16'sh7fff;
            else if (v < -48'sd32768) r = 16'sh8000;
            else r = v[15:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/gsvc_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvc_cordic
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module gsvc_cordic (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire gsvc_pkg::t_cordic_cmd    i_cmd,
    output logic                          o_busy,
    output logic signed [37:0]            o_x,
    output logic signed [37:0]            o_y,
    output logic signed [21:0]            o_z
);
    logic signed [37:0] r_x, n_x, r_y, n_y;
    logic signed [21:0] r_z, n_z;
    logic [gsvc_pkg::StepW-1:0] r_i;
    logic r_busy, r_mode;
    logic dir;

    always_comb begin
        dir = r_mode ? (r_y > 0) : (r_z >= 0);
        if (dir) begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_z = r_z - gsvc_pkg::atan_entry(5'(r_i));
        end else begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_z = r_z + gsvc_pkg::atan_entry(5'(r_i));
        end
        if (r_mode) begin
            // Vectoring steers the opposite way and accumulates angle.
            if (dir) begin
                n_x = r_x + (r_y >>> r_i);
                n_y = r_y - (r_x >>> r_i);
                n_z = r_z + gsvc_pkg::atan_entry(5'(r_i));
            end else begin
                n_x = r_x - (r_y >>> r_i);
                n_y = r_y + (r_x >>> r_i);
                n_z = r_z - gsvc_pkg::atan_entry(5'(r_i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == gsvc_pkg::StepW'(gsvc_pkg::CordicSteps - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= i_cmd.x0;
            r_y <= i_cmd.y0;
            r_z <= i_cmd.z0;
            r_mode <= i_cmd.mode;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_i == '0) || (r_i == gsvc_pkg::StepW'(gsvc_pkg::CordicSteps)))
        else $error("cordic count");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> o_busy) else $error("cordic start");
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_i < gsvc_pkg::StepW'(gsvc_pkg::CordicSteps)) else $error("cordic range");
endmodule
`default_nettype wire

// ===== src/gsvc_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvc_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gsvc_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_n,
    output logic             o_busy,
    output logic [31:0]      o_root
);
    logic [63:0] r_n, r_r, r_bit;
    logic [64:0] trial;
    logic r_busy;

    assign trial = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[1:0] != 2'b00) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if ({1'b0, r_n} >= trial) begin
                r_n <= r_n - trial[63:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[31:0];
endmodule
`default_nettype wire

// ===== src/goal_seek_velocity_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// goal_seek_velocity_controller_core
// Proportional go-to-goal speed controller with four modes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// in        input      valid / stall    t_in_item
// out       output     valid / stall    t_out_item
// cfg       input      valid / ready    2-bit mode
//
// A result is loaded into the output register once its item has run through all
// steps, and the next item is taken only after that: the squared distance, 32
// square-root steps, 16 CORDIC rotations for sin/cos and 16 vectoring steps for
// atan2 on the same unit, plus setup, scaling and output states. A zero aim vector
// skips the vectoring pass. The input stall is high while an item is in work. A
// finished result waits in the output register; if the previous result is still
// stalled there, the sequencer holds in its last state. Reset clears mode, the
// start heading and all control state.
module goal_seek_velocity_controller_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire gsvc_pkg::t_in_item    i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output gsvc_pkg::t_out_item        o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_data
);
    gsvc_pkg::t_state r_state, n_state;
    gsvc_pkg::t_in_item r_item;
    gsvc_pkg::t_out_item r_out;
    gsvc_pkg::t_cordic_cmd cmd;
    logic [1:0] r_mode;
    logic signed [15:0] r_start;
    logic r_out_valid, r_sh;
    logic signed [32:0] dx, dy, dz;
    logic [31:0] ax, ay, az;
    logic [63:0] sq_sum;
    logic [32:0] r_dist;
    logic sq_start, sq_busy;
    logic [31:0] sq_root;
    logic c_busy;
    logic signed [37:0] c_x, c_y;
    logic signed [21:0] c_z;
    logic signed [37:0] r_c, r_s;
    logic signed [22:0] e0, e1;
    logic signed [19:0] r_alpha;
    logic signed [15:0] r_ang;
    logic signed [19:0] zs;
    logic neg_sc;
    logic in_acc;
    logic out_free;
    logic r_zero_vec;

    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != gsvc_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == gsvc_pkg::S_IDLE);
    // The output register can take a new result when it is empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gsvc_pkg::ModeDrive;
            r_start <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_mode <= i_cfg_data;
            if (in_acc && i_in_item.command) r_start <= i_in_item.robot_heading;
        end
    end

    // Differences and magnitudes; halve all when any does not fit 31 bits.
    always_comb begin
        logic [32:0] mx, my, mz;
        dx = 33'(r_item.goal_x) - 33'(r_item.robot_x);
        dy = 33'(r_item.goal_y) - 33'(r_item.robot_y);
        dz = 33'(r_item.goal_z) - 33'(r_item.robot_z);
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        mz = dz[32] ? 33'(-dz) : 33'(dz);
        if (mx[32] | my[32] | mz[32] | mx[31] | my[31] | mz[31]) begin
            ax = mx[32:1]; ay = my[32:1]; az = mz[32:1];
        end else begin
            ax = mx[31:0]; ay = my[31:0]; az = mz[31:0];
        end
    end

    // Squared distance, loaded into the square-root unit as it starts.
    assign sq_sum = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gsvc_pkg::S_IDLE:   if (in_acc) n_state = gsvc_pkg::S_SQ;
            gsvc_pkg::S_SQ:     n_state = gsvc_pkg::S_SQRT;
            gsvc_pkg::S_SQRT:   if (!sq_busy) n_state = gsvc_pkg::S_SCINIT;
            gsvc_pkg::S_SCINIT: n_state = gsvc_pkg::S_SC;
            gsvc_pkg::S_SC:     if (!c_busy) n_state = gsvc_pkg::S_ATINIT;
            gsvc_pkg::S_ATINIT: n_state = gsvc_pkg::S_AT;
            gsvc_pkg::S_AT:     if (!c_busy) n_state = gsvc_pkg::S_ANG;
            gsvc_pkg::S_ANG:    n_state = gsvc_pkg::S_LIN1;
            gsvc_pkg::S_LIN1:   n_state = gsvc_pkg::S_LIN2;
            gsvc_pkg::S_LIN2:   n_state = gsvc_pkg::S_OUT;
            gsvc_pkg::S_OUT:    if (out_free) n_state = gsvc_pkg::S_IDLE;
            default:            n_state = gsvc_pkg::S_IDLE;
        endcase
    end

    // Unit commands.
    always_comb begin
        logic signed [37:0] vx, vy;
        zs = 20'(r_item.robot_heading) <<< 3;
        neg_sc = 1'b0;
        if (zs > gsvc_pkg::AngHalfPi) begin
            zs = zs - gsvc_pkg::AngPi; neg_sc = 1'b1;
        end else if (zs < -gsvc_pkg::AngHalfPi) begin
            zs = zs + gsvc_pkg::AngPi; neg_sc = 1'b1;
        end
        sq_start = (r_state == gsvc_pkg::S_SQ);
        vx = (38'(dx) <<< 3) + (38'(dx) <<< 1) - (r_c <<< 2);
        vy = (38'(dy) <<< 3) + (38'(dy) <<< 1) - (r_s <<< 2);
        cmd = '0;
        if (r_state == gsvc_pkg::S_SCINIT) begin
            cmd.start = 1'b1;
            cmd.mode  = 1'b0;
            cmd.x0    = 38'(gsvc_pkg::CordicK);
            cmd.y0    = '0;
            cmd.z0    = 22'(zs);
        end else if (r_state == gsvc_pkg::S_ATINIT) begin
            cmd.start = !(vx == '0 && vy == '0);
            cmd.mode  = 1'b1;
            if (vx < 0) begin
                cmd.x0 = -vx; cmd.y0 = -vy;
                cmd.z0 = (vy >= 0) ? 22'(gsvc_pkg::AngPi) : -22'(gsvc_pkg::AngPi);
            end else begin
                cmd.x0 = vx; cmd.y0 = vy; cmd.z0 = '0;
            end
        end
    end

    gsvc_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_start(sq_start), .i_n(sq_sum),
        .o_busy(sq_busy), .o_root(sq_root)
    );

    gsvc_cordic u_cordic (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_busy(c_busy),
        .o_x(c_x), .o_y(c_y), .o_z(c_z)
    );

    // Heading error wrapped into [-pi, pi]; a zero aim vector has target angle zero.
    always_comb begin
        e0 = (r_zero_vec ? 23'sd0 : 23'(c_z)) - (23'(r_item.robot_heading) <<< 3);
        if (e0 > 23'(gsvc_pkg::AngPi)) e1 = e0 - 23'(gsvc_pkg::AngTwoPi);
        else if (e0 < -23'(gsvc_pkg::AngPi)) e1 = e0 + 23'(gsvc_pkg::AngTwoPi);
        else e1 = e0;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            gsvc_pkg::S_IDLE: if (in_acc) r_item <= i_in_item;
            gsvc_pkg::S_SQ: begin
                r_sh <= (ax != 32'(dx[32] ? 33'(-dx) : 33'(dx)))
                     || (ay != 32'(dy[32] ? 33'(-dy) : 33'(dy)))
                     || (az != 32'(dz[32] ? 33'(-dz) : 33'(dz)));
            end
            gsvc_pkg::S_SQRT: r_dist <= r_sh ? {sq_root, 1'b0} : {1'b0, sq_root};
            gsvc_pkg::S_SC: if (!c_busy) begin
                r_c <= neg_sc ? -c_x : c_x;
                r_s <= neg_sc ? -c_y : c_y;
            end
            gsvc_pkg::S_ATINIT: r_zero_vec <= !cmd.start;
            gsvc_pkg::S_ANG: begin
                r_alpha <= 20'(e1 >>> 3);
            end
            default: ;
        endcase
    end

    // Speed law.
    logic [19:0] amag;
    logic signed [19:0] alpha_dz;
    logic signed [47:0] prod;
    logic signed [16:0] fct;
    logic signed [15:0] ang_d;
    logic [17:0] hmag;
    logic signed [17:0] he;

    always_comb begin
        logic signed [17:0] h0;
        amag = r_alpha[19] ? 20'(-r_alpha) : 20'(r_alpha);
        alpha_dz = (amag < 20'd41) ? '0 : r_alpha;
        prod = 48'(alpha_dz) * 48'sd39322;
        ang_d = gsvc_pkg::sat16(prod >>> 17);
        h0 = 18'(r_item.robot_heading) - 18'(r_start);
        if (h0 > gsvc_pkg::Q13Pi) he = h0 - gsvc_pkg::Q13TwoPi;
        else if (h0 < -gsvc_pkg::Q13Pi) he = h0 + gsvc_pkg::Q13TwoPi;
        else he = h0;
        hmag = he[17] ? 18'(-he) : 18'(he);
        fct = 17'sd4915 - ((r_mode == gsvc_pkg::ModeDrive) ?
              17'(r_ang[15] ? -17'(r_ang) : 17'(r_ang)) : 17'sd0);
    end

    logic signed [47:0] r_df;

    always_ff @(posedge i_clk) begin
        if (r_state == gsvc_pkg::S_LIN1) begin
            r_ang <= ang_d;
        end
        if (r_state == gsvc_pkg::S_LIN2) begin
            r_df <= 48'(r_dist) * 48'(fct);
        end
    end

    logic signed [63:0] lt;
    logic signed [15:0] lin_d, ang_a;
    always_comb begin
        lt = 64'(r_df) * 64'sd6554;
        lin_d = gsvc_pkg::sat16(48'(lt >>> 32) + 48'sd614);
        ang_a = gsvc_pkg::sat16((48'(r_alpha) * 48'sd39322 >>> 17)
                + (r_alpha > 0 ? 48'sd819 : -48'sd819));
    end

    // Result of the current mode; speeds stay zero when the stop condition holds.
    gsvc_pkg::t_out_item out_d;
    always_comb begin
        out_d = '0;
        unique case (r_mode)
            gsvc_pkg::ModeDrive:
                if (r_dist < 33'd32768) out_d.done_res = 1'b1;
                else begin
                    out_d.angular_speed = r_ang;
                    out_d.linear_speed = lin_d;
                end
            gsvc_pkg::ModeAlign:
                if (amag < 20'd49) out_d.done_res = 1'b1;
                else out_d.angular_speed = ang_a;
            gsvc_pkg::ModeClose:
                if (r_dist < 33'd6554) out_d.done_res = 1'b1;
                else out_d.linear_speed = lin_d;
            default:
                if (hmag > 18'd24097) out_d.done_res = 1'b1;
                else out_d.angular_speed = 16'sd4096;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == gsvc_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gsvc_pkg::S_OUT && out_free) begin
            r_out <= out_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gsvc_pkg::S_IDLE;
        else r_state <= n_state;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != gsvc_pkg::S_IDLE |-> o_in_stall) else $error("accept while busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |->
        o_out_item.linear_speed == 0 && o_out_item.angular_speed == 0)
        else $error("done with speed");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |-> o_out_valid) else $error("result lost");
endmodule
`default_nettype wire

// ===== tb/sv/gsvc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gsvc_checker
// Watches the item channels of the velocity controller, computes the
// expected speed commands in fixed point and compares them with each result.
// ----------------------------------------------------------------------------
module gsvc_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire gsvc_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire gsvc_pkg::t_out_item i_out_item,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire logic [1:0]          i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_result_count
);
    localparam longint AtanTab[24] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0, 0, 0, 0, 0};

    logic [1:0]  cur_mode;
    longint      latched_heading;
    gsvc_pkg::t_out_item cmd_queue[$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint lin_cmd(longint dist_q, longint ang);
        longint f;
        f = 4915 - absval(ang);
        return clip16(614 + shr_floor(dist_q * 6554 * f, 32));
    endfunction

    function automatic gsvc_pkg::t_out_item predict_cmd(gsvc_pkg::t_in_item it);
        longint h, dx, dy, dz, ax, ay, az, dist_q, e, alpha, lin, ang;
        longint z, x, y, xn, c, s, tgt;
        longint unsigned sum;
        bit neg, done;
        int sh;
        gsvc_pkg::t_out_item r;
        lin = 0;
        ang = 0;
        done = 0;
        h = it.robot_heading;
        if (it.command) latched_heading = h;
        dx = longint'(it.goal_x) - longint'(it.robot_x);
        dy = longint'(it.goal_y) - longint'(it.robot_y);
        dz = longint'(it.goal_z) - longint'(it.robot_z);
        ax = absval(dx); ay = absval(dy); az = absval(dz);
        sh = (ax >= 64'sd2147483648 || ay >= 64'sd2147483648 || az >= 64'sd2147483648);
        ax >>= sh; ay >>= sh; az >>= sh;
        sum = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
        dist_q = longint'(root64(sum) << sh);
        // Heading sin/cos by rotation, folded into the right half plane first.
        z = h * 8; x = 9949; y = 0; neg = 0;
        if (z > 102944) begin z -= 205887; neg = 1; end
        else if (z < -102944) begin z += 205887; neg = 1; end
        for (int i = 0; i < gsvc_pkg::CordicSteps && i < 24; i++) begin
            if (z >= 0) begin
                xn = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= AtanTab[i];
            end else begin
                xn = x + shr_floor(y, i); y = y - shr_floor(x, i); z += AtanTab[i];
            end
            x = xn;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
        // Aim angle by vectoring; a zero vector gives zero.
        y = 10 * dy - 4 * s;
        x = 10 * dx - 4 * c;
        tgt = 0;
        if (!(x == 0 && y == 0)) begin
            if (x < 0) begin
                tgt = (y >= 0) ? 205887 : -205887; x = -x; y = -y;
            end
            for (int i = 0; i < gsvc_pkg::CordicSteps && i < 24; i++) begin
                if (y > 0) begin
                    xn = x + shr_floor(y, i); y = y - shr_floor(x, i); tgt += AtanTab[i];
                end else begin
                    xn = x - shr_floor(y, i); y = y + shr_floor(x, i); tgt -= AtanTab[i];
                end
                x = xn;
            end
        end
        e = tgt - h * 8;
        while (e > 205887) e -= 411775;
        while (e < -205887) e += 411775;
        alpha = shr_floor(e, 3);
        case (cur_mode)
            gsvc_pkg::ModeDrive: begin
                if (dist_q < 32768) done = 1;
                else begin
                    if (absval(alpha) < 41) alpha = 0;
                    ang = clip16(shr_floor(alpha * 39322, 17));
                    lin = lin_cmd(dist_q, ang);
                end
            end
            gsvc_pkg::ModeAlign: begin
                if (absval(alpha) < 49) done = 1;
                else ang = clip16(shr_floor(alpha * 39322, 17) + (alpha > 0 ? 819 : -819));
            end
            gsvc_pkg::ModeClose: begin
                if (dist_q < 6554) done = 1;
                else lin = lin_cmd(dist_q, 0);
            end
            default: begin
                e = h - latched_heading;
                while (e > 25736) e -= 51472;
                while (e < -25736) e += 51472;
                if (absval(e) > 24097) done = 1;
                else ang = 4096;
            end
        endcase
        r.linear_speed  = lin[15:0];
        r.angular_speed = ang[15:0];
        r.done_res      = done;
        return r;
    endfunction

    always @(posedge i_clk) begin
        gsvc_pkg::t_out_item want;
        if (!i_rst_n) begin
            cur_mode <= gsvc_pkg::ModeDrive;
            latched_heading = 0;
            o_fail_count <= 0;
            o_result_count <= 0;
            cmd_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) cur_mode <= i_cfg_data;
            if (i_in_valid && !i_in_stall) cmd_queue = {cmd_queue, predict_cmd(i_in_item)};
            if (i_out_valid && !i_out_stall) begin
                o_result_count <= o_result_count + 1;
                if (cmd_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cmd_queue.pop_front();
                    if (want !== i_out_item) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected lin %0d ang %0d done %0d, ",
                                      "got lin %0d ang %0d done %0d"},
                                want.linear_speed, want.angular_speed, want.done_res,
                                i_out_item.linear_speed, i_out_item.angular_speed,
                                i_out_item.done_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = cmd_queue.size();

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the go-to-goal velocity controller: directed
// corner ticks, then random ticks in every mode with random idle gaps.
// ----------------------------------------------------------------------------
module tb;
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    gsvc_pkg::t_in_item  in_item;
    logic       out_valid;
    logic       out_stall;
    gsvc_pkg::t_out_item out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending;
    int         result_count;
    int         cycle_count;
    bit         stall_random;

    // Run limit in clock cycles; the 937 items with long gaps on both sides stay
    // far below it.
    localparam int CycleLimit = 1000000;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    goal_seek_velocity_controller_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    gsvc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // The receiver stalls at random; some stretches keep the stall low.
    always @(posedge clk) begin
        if (!rst_n || !stall_random) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < 30) ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[goal_seek_velocity_controller_core] ERROR");
            $finish;
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // Offers one item and holds it until the block takes it. Valid stays high
    // into the next item when there is no gap.
    task automatic send_tick(gsvc_pkg::t_in_item it);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            idle_cycles(gap);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Waits for every expected result, then lets the unit run dry.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        idle_cycles(100);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic gsvc_pkg::t_in_item near_tick(int spread);
        gsvc_pkg::t_in_item it;
        it.command       = ($urandom_range(0, 9) == 0);
        it.robot_x       = $urandom;
        it.robot_y       = $urandom;
        it.robot_z       = $urandom;
        it.robot_heading = 16'($signed($urandom_range(0, 51472)) - 25736);
        it.goal_x = it.robot_x + 32'($signed($urandom_range(0, 2 * spread)) - spread);
        it.goal_y = it.robot_y + 32'($signed($urandom_range(0, 2 * spread)) - spread);
        it.goal_z = it.robot_z + 32'($signed($urandom_range(0, spread / 8)) - spread / 16);
        return it;
    endfunction

    function automatic gsvc_pkg::t_in_item wild_tick();
        gsvc_pkg::t_in_item it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(gsvc_pkg::t_in_item)-1:0];
        return it;
    endfunction

    task automatic random_phase(int n);
        int p;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 45) send_tick(near_tick(8192));
            else if (p < 85) send_tick(near_tick(600000));
            else send_tick(wild_tick());
        end
    endtask

    initial begin
        gsvc_pkg::t_in_item it;
        rst_n = 1'b0; in_valid = 1'b0; in_item = '0; cfg_valid = 1'b0;
        cfg_data = gsvc_pkg::ModeDrive;
        cycle_count = 0; stall_random = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero aim vector, extreme positions and headings, half turn.
        it = '0;
        send_tick(it);
        it = '0; it.goal_x = 32'sh7fffffff; it.robot_x = 32'sh80000000;
        it.robot_y = 32'sh7fffffff; it.goal_y = 32'sh80000000; it.goal_z = 32'sh7fffffff;
        send_tick(it);
        it = '0; it.robot_heading = 16'sh7fff; it.goal_x = 32'sh00010000;
        send_tick(it);
        it = '0; it.robot_heading = 16'sh8000; it.goal_y = -32'sh00030000;
        send_tick(it);
        it = '0; it.robot_heading = 16'sd25736; it.goal_x = 32'sh00008000;
        send_tick(it);
        it = '0; it.goal_y = 32'sh00100000; it.robot_heading = -16'sd25736;
        send_tick(it);  // goal a quarter turn off: large angular speed lowers linear speed
        it = '0; it.goal_x = 32'sh00001000;
        send_tick(it);
        set_mode(gsvc_pkg::ModeAlign);
        it = '0; it.goal_x = 32'sh00010000; send_tick(it);
        it.goal_y = 32'sh00010000; send_tick(it);
        it.goal_y = -32'sh00050000; send_tick(it);
        set_mode(gsvc_pkg::ModeClose);
        it = '0; it.goal_x = 32'sh00001000; send_tick(it);
        it.goal_x = 32'sh7fffffff; send_tick(it);
        set_mode(gsvc_pkg::ModeTurn);
        it = '0; it.command = 1; it.robot_heading = -16'sd25000; send_tick(it);
        it.command = 0; it.robot_heading = 16'sd0; send_tick(it);
        it.robot_heading = 16'sd24000; send_tick(it);
        it.robot_heading = 16'sd25736; send_tick(it);
        it.robot_heading = 16'sh7fff; send_tick(it);

        // Random: each phase in one mode, with the extremes revisited.
        stall_random = 1;
        for (int ph = 0; ph < 12; ph++) begin
            set_mode(2'($urandom_range(0, 3)));
            random_phase(60);
            if (ph == 5) drain();  // sender holds until all results are back
        end
        set_mode(gsvc_pkg::ModeDrive);  random_phase(50);
        set_mode(gsvc_pkg::ModeTurn);   random_phase(50);
        set_mode(gsvc_pkg::ModeAlign);  random_phase(50);
        set_mode(gsvc_pkg::ModeClose);  random_phase(50);

        drain();
        $display("ran %0d results across all four modes, with random gaps and stalls",
                 result_count);
        if (fail_count == 0) $display("[goal_seek_velocity_controller_core] OK");
        else $display("[goal_seek_velocity_controller_core] ERROR");
        $finish;
    end

endmodule
